[rtl/core/mrr_pkg.sv]
// Shared types, constants and routing function for the mesh router.
// No dependencies; every other file takes names from here by scope.
package mrr_pkg;

  localparam int PORT_COUNT      = 20;
  localparam int FORWARD_LATENCY = 4;
  localparam int PORT_W          = 5;
  localparam int LOCAL_PORTS     = 16;
  localparam int TIME_W          = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;
  localparam int STEP_W          = 5;
  // try steps per tick: the round-robin winner, then every port in order
  localparam int TRY_STEPS       = PORT_COUNT + 1;

  localparam logic [PORT_W-1:0] PORT_NORTH = PORT_W'(16);
  localparam logic [PORT_W-1:0] PORT_EAST  = PORT_W'(17);
  localparam logic [PORT_W-1:0] PORT_SOUTH = PORT_W'(18);
  localparam logic [PORT_W-1:0] PORT_WEST  = PORT_W'(19);
  localparam logic [PORT_W-1:0] PORT_LAST  = PORT_W'(PORT_COUNT - 1);

  typedef enum logic [2:0] {
    EV_ACCEPTED   = 3'd0,
    EV_REJECTED   = 3'd1,
    EV_FORWARDED  = 3'd2,
    EV_NO_CHILD   = 3'd3,
    EV_NO_NEIGHBOR = 3'd4,
    EV_TICK_DONE  = 3'd5
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SUBNET   = 2'd0,
    REG_CHILD    = 2'd1,
    REG_NEIGHBOR = 2'd2,
    REG_UNUSED   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FREE,
    ST_TRY,
    ST_DONE
  } state_t;

  // classified command waiting between front and back
  typedef struct packed {
    logic              is_tick;
    logic              port_ok;
    logic [PORT_W-1:0] port;
    logic [15:0]       dest;
    logic [15:0]       src;
    logic [7:0]        size;
  } qitem_t;

  typedef struct packed {
    logic [11:0] subnet;
    logic [15:0] child;
    logic [3:0]  neighbor;
  } cfg_t;

  typedef struct packed {
    logic [PORT_W-1:0] rr;
    logic              busy;
  } status_t;

  // XY route of a destination address seen from this router
  function automatic logic [PORT_W-1:0] route_port(logic [15:0] addr, logic [11:0] subnet);
    logic [1:0] my_x;
    logic [9:0] my_y;
    logic [1:0] tx;
    logic [9:0] ty;
    logic [PORT_W-1:0] res;
    my_x = subnet[1:0];
    my_y = subnet[11:2];
    tx   = addr[5:4];
    ty   = addr[15:6];
    if (addr[15:4] == subnet) begin
      res = {1'b0, addr[3:0]};
    end else if (ty == my_y) begin
      res = (tx > my_x) ? PORT_EAST : PORT_WEST;
    end else if (tx == my_x) begin
      res = (ty > my_y) ? PORT_SOUTH : PORT_NORTH;
    end else begin
      res = (tx > my_x) ? PORT_EAST : PORT_WEST;
    end
    return res;
  endfunction

endpackage

[rtl/core/mrr_ifs.sv]
// Valid/ready channel interfaces: command input, event output, config write.
// Depends on mrr_pkg for widths.
interface mrr_in_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [mrr_pkg::PORT_W-1:0] in_port;
  logic [15:0]               dest_addr;
  logic [15:0]               src_addr;
  logic [7:0]                size_words;
  modport source (output valid, cmd, in_port, dest_addr, src_addr, size_words, input ready);
  modport sink (input valid, cmd, in_port, dest_addr, src_addr, size_words, output ready);
endinterface

interface mrr_out_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                event_res;
  logic [mrr_pkg::PORT_W-1:0] from_port;
  logic [mrr_pkg::PORT_W-1:0] to_port;
  logic [15:0]               out_dest_addr;
  logic [15:0]               out_src_addr;
  logic [7:0]                out_size_words;
  logic                      last;
  modport source (output valid, event_res, from_port, to_port, out_dest_addr,
                  out_src_addr, out_size_words, last, input ready);
  modport sink (input valid, event_res, from_port, to_port, out_dest_addr,
                out_src_addr, out_size_words, last, output ready);
endinterface

interface mrr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mrr_pkg::CFG_IDX_W-1:0]   index;
  logic [mrr_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/mrr_front.sv]
// Front end: accepts commands and classifies them for the back end.
// Depends on mrr_pkg and mrr_ifs.
module mrr_front (
  mrr_in_if.sink          in_ch,
  output logic            push_valid,
  input  logic            push_ready,
  output mrr_pkg::qitem_t push_item
);

  // accept whenever the queue has room
  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  // decode command and range-check the port
  always_comb begin
    push_item.is_tick = in_ch.cmd;
    push_item.port_ok = (in_ch.in_port < mrr_pkg::PORT_W'(mrr_pkg::PORT_COUNT));
    push_item.port    = in_ch.in_port;
    push_item.dest    = in_ch.dest_addr;
    push_item.src     = in_ch.src_addr;
    push_item.size    = in_ch.size_words;
  end

endmodule

[rtl/core/mrr_queue.sv]
// Two-entry queue of classified commands between front and back.
// Depends on mrr_pkg.
module mrr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  mrr_pkg::qitem_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output mrr_pkg::qitem_t pop_item
);

  mrr_pkg::qitem_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_item;
  end

endmodule

[rtl/core/mrr_back.sv]
// Back end: inbox state, output-port timers, tick sequencer, output register.
// Depends on mrr_pkg and mrr_ifs.
module mrr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  mrr_pkg::qitem_t    pop_item,
  input  mrr_pkg::cfg_t      cfg,
  mrr_out_if.source          out_ch,
  output mrr_pkg::status_t   status
);

  localparam int PC = mrr_pkg::PORT_COUNT;
  localparam int PW = mrr_pkg::PORT_W;
  localparam int TW = mrr_pkg::TIME_W;

  // inbox and output-port state
  logic          inbox_full       [PC];
  logic [15:0]   inbox_dest       [PC];
  logic [15:0]   inbox_src        [PC];
  logic [7:0]    inbox_size       [PC];
  logic [TW-1:0] inbox_ready_time [PC];
  logic          outport_busy      [PC];
  logic [TW-1:0] outport_free_time [PC];
  logic [PW-1:0] rr_pointer;
  logic [TW-1:0] tick_time;

  mrr_pkg::state_t st, st_next;
  logic [mrr_pkg::STEP_W-1:0] step;

  // output register
  logic        o_valid;
  logic [2:0]  o_event;
  logic [PW-1:0] o_from;
  logic [PW-1:0] o_to;
  logic [15:0] o_dest;
  logic [15:0] o_src;
  logic [7:0]  o_size;
  logic        o_last;
  logic        slot_ok;
  logic        o_load;

  // step datapath
  logic [PW-1:0] idx;
  logic          try_ok;
  logic [PW-1:0] dst;
  logic          present;
  logic          act;
  mrr_pkg::event_t try_ev;
  logic          arr_ok;
  logic [TW-1:0] due_time;
  logic [PW-1:0] rr_inc;

  assign slot_ok  = !o_valid || out_ch.ready;
  assign due_time = tick_time + TW'(mrr_pkg::FORWARD_LATENCY);
  assign rr_inc   = (rr_pointer == mrr_pkg::PORT_LAST) ? '0 : rr_pointer + PW'(1);

  // a new event enters the output register this cycle
  assign o_load = slot_ok &&
                  ((st == mrr_pkg::ST_IDLE && pop_valid && !pop_item.is_tick) ||
                   (st == mrr_pkg::ST_TRY && act) ||
                   (st == mrr_pkg::ST_DONE));

  // inbox under test and its route
  always_comb begin
    idx     = (step == '0) ? rr_pointer : PW'(step - mrr_pkg::STEP_W'(1));
    try_ok  = inbox_full[idx] && !(inbox_ready_time[idx] > tick_time);
    dst     = mrr_pkg::route_port(inbox_dest[idx], cfg.subnet);
    present = (dst < PW'(mrr_pkg::LOCAL_PORTS)) ? cfg.child[dst[3:0]]
                                                : cfg.neighbor[dst[1:0]];
    act     = try_ok && !outport_busy[dst];
    if (present) try_ev = mrr_pkg::EV_FORWARDED;
    else if (dst < PW'(mrr_pkg::LOCAL_PORTS)) try_ev = mrr_pkg::EV_NO_CHILD;
    else try_ev = mrr_pkg::EV_NO_NEIGHBOR;
    arr_ok  = pop_item.port_ok && !inbox_full[pop_item.port];
  end

  // next state
  always_comb begin
    st_next = st;
    case (st)
      mrr_pkg::ST_IDLE: begin
        if (pop_valid && pop_item.is_tick) st_next = mrr_pkg::ST_FREE;
      end
      mrr_pkg::ST_FREE: st_next = mrr_pkg::ST_TRY;
      mrr_pkg::ST_TRY: begin
        if ((slot_ok || !act) && step == mrr_pkg::STEP_W'(mrr_pkg::TRY_STEPS - 1))
          st_next = mrr_pkg::ST_DONE;
      end
      mrr_pkg::ST_DONE: begin
        if (slot_ok) st_next = mrr_pkg::ST_IDLE;
      end
      default: st_next = mrr_pkg::ST_IDLE;
    endcase
  end

  // queue pop: an arrival leaves at once, a tick when its last result goes out
  always_comb begin
    case (st)
      mrr_pkg::ST_IDLE: pop_ready = pop_valid && !pop_item.is_tick && slot_ok;
      mrr_pkg::ST_DONE: pop_ready = slot_ok;
      default:          pop_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= mrr_pkg::ST_IDLE;
    else     st <= st_next;
  end

  // sequencer, state updates and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= '0;
      rr_pointer <= '0;
      tick_time  <= '0;
      o_valid    <= 1'b0;
      for (int i = 0; i < PC; i++) begin
        inbox_full[i]        <= 1'b0;
        inbox_ready_time[i]  <= '0;
        outport_busy[i]      <= 1'b0;
        outport_free_time[i] <= '0;
      end
    end else begin
      o_valid <= o_load || (o_valid && !out_ch.ready);
      case (st)
        mrr_pkg::ST_IDLE: begin
          step <= '0;
          if (pop_valid && !pop_item.is_tick && slot_ok) begin
            o_event <= arr_ok ? mrr_pkg::EV_ACCEPTED : mrr_pkg::EV_REJECTED;
            o_from  <= pop_item.port;
            o_to    <= '0;
            o_dest  <= pop_item.dest;
            o_src   <= pop_item.src;
            o_size  <= pop_item.size;
            o_last  <= 1'b1;
            if (arr_ok) begin
              inbox_full[pop_item.port]       <= 1'b1;
              inbox_ready_time[pop_item.port] <= due_time;
            end
          end
        end
        mrr_pkg::ST_FREE: begin
          for (int i = 0; i < PC; i++)
            if (outport_busy[i] && outport_free_time[i] < tick_time)
              outport_busy[i] <= 1'b0;
        end
        mrr_pkg::ST_TRY: begin
          if (act && slot_ok) begin
            o_event <= try_ev;
            o_from  <= idx;
            o_to    <= dst;
            o_dest  <= inbox_dest[idx];
            o_src   <= inbox_src[idx];
            o_size  <= inbox_size[idx];
            o_last  <= 1'b0;
            inbox_full[idx] <= 1'b0;
            if (try_ev == mrr_pkg::EV_FORWARDED) begin
              outport_busy[dst]      <= 1'b1;
              outport_free_time[dst] <= due_time;
              rr_pointer             <= rr_inc;
            end
          end
          if (slot_ok || !act) step <= step + mrr_pkg::STEP_W'(1);
        end
        mrr_pkg::ST_DONE: begin
          if (slot_ok) begin
            o_event   <= mrr_pkg::EV_TICK_DONE;
            o_from    <= '0;
            o_to      <= '0;
            o_dest    <= '0;
            o_src     <= '0;
            o_size    <= '0;
            o_last    <= 1'b1;
            tick_time <= tick_time + TW'(1);
          end
        end
        default: step <= '0;
      endcase
    end
  end

  // payload written only on arrival
  always_ff @(posedge clk) begin
    if (st == mrr_pkg::ST_IDLE && pop_valid && !pop_item.is_tick && slot_ok && arr_ok) begin
      inbox_dest[pop_item.port] <= pop_item.dest;
      inbox_src[pop_item.port]  <= pop_item.src;
      inbox_size[pop_item.port] <= pop_item.size;
    end
  end

  assign out_ch.valid          = o_valid;
  assign out_ch.event_res      = o_event;
  assign out_ch.from_port      = o_from;
  assign out_ch.to_port        = o_to;
  assign out_ch.out_dest_addr  = o_dest;
  assign out_ch.out_src_addr   = o_src;
  assign out_ch.out_size_words = o_size;
  assign out_ch.last           = o_last;

  assign status.rr   = rr_pointer;
  assign status.busy = (st != mrr_pkg::ST_IDLE);

endmodule

[rtl/core/mesh_router_xy_round_robin.sv]
// Top level of the 20-port XY mesh router: config registers, front, queue, back.
// Depends on mrr_pkg, mrr_ifs, mrr_front, mrr_queue and mrr_back.

// An arrival command gives one event in the back end once it reaches the head
// of the two-entry command queue. A tick is recognized at the head of the queue,
// then releases expired output ports, makes 21 inbox tries - the round-robin
// winner first, then ports 0 to 19 - and closes with the tick-done event; the
// try sequencer tests a single inbox per cycle, but a try or event that has to
// load the event output register waits while that register stays occupied.
// Config writes are always taken and must only be issued while the router is idle.
module mesh_router_xy_round_robin (
  input  logic clk,
  input  logic rst,
  mrr_in_if.sink     in_ch,
  mrr_out_if.source  out_ch,
  mrr_cfg_if.sink    cfg_ch
);

  mrr_pkg::cfg_t    cfg;
  mrr_pkg::qitem_t  push_item;
  mrr_pkg::qitem_t  pop_item;
  mrr_pkg::status_t status;
  logic push_valid, push_ready, pop_valid, pop_ready;

  // configuration registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_ch.valid) begin
      case (mrr_pkg::reg_idx_t'(cfg_ch.index))
        mrr_pkg::REG_SUBNET:   cfg.subnet   <= cfg_ch.data[11:0];
        mrr_pkg::REG_CHILD:    cfg.child    <= cfg_ch.data;
        mrr_pkg::REG_NEIGHBOR: cfg.neighbor <= cfg_ch.data[3:0];
        default: ;
      endcase
    end
  end

  mrr_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  mrr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  mrr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .cfg       (cfg),
    .out_ch    (out_ch),
    .status    (status)
  );

`ifndef SYNTH
  // round-robin pointer stays within the port range
  a_rr_range: assert property (@(posedge clk) disable iff (rst)
    status.rr < mrr_pkg::PORT_W'(mrr_pkg::PORT_COUNT))
    else $error("rr pointer out of range");

  // tick-done and arrival events always close their command
  a_last_events: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.event_res == mrr_pkg::EV_TICK_DONE ||
                     out_ch.event_res == mrr_pkg::EV_ACCEPTED ||
                     out_ch.event_res == mrr_pkg::EV_REJECTED) |-> out_ch.last)
    else $error("closing event without last");

  // a command leaves the queue only while the back end is busy with it or idle
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop_ready && !pop_item.is_tick |-> !status.busy)
    else $error("arrival popped during a tick");
`endif

endmodule
